>>> hdl/rtue_pkg.sv
`timescale 1ns / 1ps

package rtue_pkg;

    localparam int MAX_NODES = 16;
    localparam int MAX_GATES = 8;
    localparam int NODE_W    = 4;
    localparam int GATE_W    = 3;
    localparam int COST_W    = 8;
    localparam int COUNT_W   = $clog2(MAX_NODES + 1);
    localparam int ADDR_W    = NODE_W + GATE_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_COUNT = 2'd1;

    localparam logic [3:0] GATE_COUNT_RESET = 4'd8;

    localparam logic CMD_DISCOVERY = 1'b0;
    localparam logic CMD_ADVERTISE = 1'b1;

    typedef struct packed {
        logic                command;
        logic [NODE_W-1:0]   node_id;
        logic [GATE_W-1:0]   arrival_gate;
        logic [COST_W-1:0]   advertised_cost;
        logic                last_entry;
    } t_item;

    typedef struct packed {
        logic [NODE_W-1:0]   dest_node;
        logic [COST_W-1:0]   route_cost;
        logic                final_entry;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic                take;
        logic [NODE_W-1:0]   node;
        logic [GATE_W-1:0]   gate;
        logic                sel_best;
        logic                scan_start;
        logic                scan_rd;
        logic                scan_apply;
        logic                clr_changed;
        logic                emit_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic                disc_emit;
        logic                known;
        logic                changed;
        logic                out_free;
    } t_stat;

endpackage

>>> hdl/rtue_if.sv
`timescale 1ns / 1ps

interface rtue_item_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic [rtue_pkg::NODE_W-1:0]        node_id;
    logic [rtue_pkg::GATE_W-1:0]        arrival_gate;
    logic [rtue_pkg::COST_W-1:0]        advertised_cost;
    logic                               last_entry;

    modport source (output valid, command, node_id, arrival_gate, advertised_cost,
                    last_entry, input ready);
    modport sink   (input valid, command, node_id, arrival_gate, advertised_cost,
                    last_entry, output ready);
endinterface

interface rtue_result_if;
    logic                               valid;
    logic                               ready;
    logic [rtue_pkg::NODE_W-1:0]        dest_node;
    logic [rtue_pkg::COST_W-1:0]        route_cost;
    logic                               final_entry;

    modport source (output valid, dest_node, route_cost, final_entry, input ready);
    modport sink   (input valid, dest_node, route_cost, final_entry, output ready);
endinterface

interface rtue_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rtue_pkg::CFG_IDX_W-1:0]     index;
    logic [rtue_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/route_table_update_engine_unit.sv
`timescale 1ns / 1ps
// A discovery or non-final advertisement entry is handled when it is taken, plus a table emission
// when the known node count after a discovery equals gate_count. A final entry runs a best gate
// pass over all nodes that reads the cost RAM for all 8 gates of each known node, then an
// emission if the table changed: one result per known node, held back by output stalls.
// A new item is taken only once the controller is idle again after the scan and emission.
// Reset: sync active low; clears node flags, masks, best gates; own_node 0, gate_count 8.

module route_table_update_engine_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rtue_item_if.sink         i_item,
    rtue_result_if.source     o_result,
    rtue_cfg_if.sink          i_cfg
);

    rtue_pkg::t_cmd    w_cmd;
    rtue_pkg::t_stat   w_stat;
    rtue_pkg::t_item   w_item;
    rtue_pkg::t_result w_out;
    logic              w_acc;
    logic              w_out_valid;
    logic              w_cfg_we;

    // Pack the incoming transaction for the controller and datapath.
    assign w_item.command         = i_item.command;
    assign w_item.node_id         = i_item.node_id;
    assign w_item.arrival_gate    = i_item.arrival_gate;
    assign w_item.advertised_cost = i_item.advertised_cost;
    assign w_item.last_entry      = i_item.last_entry;

    // Accept items only while the controller is idle; the output register
    // still may hold a result waiting for the sink.
    assign i_item.ready = w_cmd.take;
    assign w_acc        = i_item.valid && w_cmd.take;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;

    rtue_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_item  (w_item),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    rtue_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_acc       (w_acc),
        .i_item      (w_item),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_result.ready),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

    // Drive the result transaction straight from the output register.
    assign o_result.valid       = w_out_valid;
    assign o_result.dest_node   = w_out.dest_node;
    assign o_result.route_cost  = w_out.route_cost;
    assign o_result.final_entry = w_out.final_entry;

    // The controller comes out of reset idle and ready for a transaction.
    a_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> i_item.ready)
        else $error("item ready low right after reset");

    // Never take an item while the best gate scan owns the cost RAM.
    a_no_take_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_rd |-> !i_item.ready)
        else $error("item ready during best gate scan");

    // Never overwrite a result that the sink has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_load |-> (!o_result.valid || o_result.ready))
        else $error("result register overwritten");

    // A loaded result shows up as valid in the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_load |=> o_result.valid)
        else $error("loaded result not presented");

endmodule

>>> hdl/rtue_ram.sv
`timescale 1ns / 1ps

module rtue_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rtue_ctrl.sv
`timescale 1ns / 1ps

module rtue_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  rtue_pkg::t_item  i_item,
    input  rtue_pkg::t_stat  i_stat,
    output rtue_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RC_NODE  = 3'd1;
    localparam logic [2:0] S_RC_SCAN  = 3'd2;
    localparam logic [2:0] S_RC_DRAIN = 3'd3;
    localparam logic [2:0] S_RC_FIN   = 3'd4;
    localparam logic [2:0] S_EM_RD    = 3'd5;
    localparam logic [2:0] S_EM_LD    = 3'd6;

    localparam logic [rtue_pkg::NODE_W-1:0] LAST_NODE =
        rtue_pkg::NODE_W'(rtue_pkg::MAX_NODES - 1);
    localparam logic [rtue_pkg::GATE_W-1:0] LAST_GATE =
        rtue_pkg::GATE_W'(rtue_pkg::MAX_GATES - 1);

    logic [2:0]                    r_state, n_state;
    logic [rtue_pkg::NODE_W-1:0]   r_node, n_node;
    logic [rtue_pkg::GATE_W-1:0]   r_gate, n_gate;
    logic                          w_last_node;

    assign w_last_node = (r_node == LAST_NODE);

    always_comb begin
        n_state = r_state;
        n_node  = r_node;
        n_gate  = r_gate;
        o_cmd             = '0;
        o_cmd.node        = r_node;
        o_cmd.gate        = r_gate;
        o_cmd.take        = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                n_node = '0;
                if (i_acc) begin
                    if (i_item.command == rtue_pkg::CMD_DISCOVERY) begin
                        if (i_stat.disc_emit) begin
                            n_state = S_EM_RD;
                        end
                    end else if (i_item.last_entry) begin
                        n_state = S_RC_NODE;
                    end
                end
            end
            S_RC_NODE: begin
                o_cmd.scan_start = 1'b1;
                n_gate = '0;
                if (i_stat.known) begin
                    n_state = S_RC_SCAN;
                end else if (w_last_node) begin
                    o_cmd.clr_changed = 1'b1;
                    n_node  = '0;
                    n_state = i_stat.changed ? S_EM_RD : S_IDLE;
                end else begin
                    n_node = r_node + 1'b1;
                end
            end
            S_RC_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                n_gate = r_gate + 1'b1;
                if (r_gate == LAST_GATE) begin
                    n_state = S_RC_DRAIN;
                end
            end
            S_RC_DRAIN: begin
                n_state = S_RC_FIN;
            end
            S_RC_FIN: begin
                o_cmd.scan_apply = 1'b1;
                if (w_last_node) begin
                    o_cmd.clr_changed = 1'b1;
                    n_node  = '0;
                    n_state = i_stat.changed ? S_EM_RD : S_IDLE;
                end else begin
                    n_node  = r_node + 1'b1;
                    n_state = S_RC_NODE;
                end
            end
            S_EM_RD: begin
                o_cmd.sel_best = 1'b1;
                if (i_stat.known) begin
                    n_state = S_EM_LD;
                end else if (w_last_node) begin
                    n_state = S_IDLE;
                end else begin
                    n_node = r_node + 1'b1;
                end
            end
            S_EM_LD: begin
                o_cmd.sel_best = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (w_last_node) begin
                        n_state = S_IDLE;
                    end else begin
                        n_node  = r_node + 1'b1;
                        n_state = S_EM_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_node  <= '0;
            r_gate  <= '0;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
            r_gate  <= n_gate;
        end
    end

endmodule

>>> hdl/rtue_dp.sv
`timescale 1ns / 1ps

module rtue_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rtue_pkg::t_cmd                    i_cmd,
    output rtue_pkg::t_stat                   o_stat,
    input  logic                              i_acc,
    input  rtue_pkg::t_item                   i_item,
    input  logic                              i_cfg_we,
    input  logic [rtue_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rtue_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output rtue_pkg::t_result                 o_out
);

    localparam int NODES = rtue_pkg::MAX_NODES;
    localparam int GATES = rtue_pkg::MAX_GATES;

    // configuration
    logic [rtue_pkg::NODE_W-1:0]   r_own_node;
    logic [3:0]                    r_gate_count;

    // table state
    logic [NODES-1:0]              r_known;
    logic [GATES-1:0]              r_mask [NODES];
    logic [rtue_pkg::GATE_W-1:0]   r_best [NODES];
    logic [rtue_pkg::COUNT_W-1:0]  r_count;
    logic                          r_changed;

    // best gate search
    logic                          r_pend;
    logic [rtue_pkg::GATE_W-1:0]   r_pend_gate;
    logic                          r_min_vld;
    logic [rtue_pkg::COST_W-1:0]   r_min;
    logic [rtue_pkg::GATE_W-1:0]   r_arg;
    logic [rtue_pkg::COST_W-1:0]   r_best_cost;

    // output register
    logic                          r_out_valid;
    rtue_pkg::t_result             r_out;

    logic                          w_fits;
    logic                          w_new_node;
    logic                          w_disc;
    logic                          w_adv_store;
    logic [rtue_pkg::COST_W:0]     w_cost_sum;
    logic [rtue_pkg::COST_W-1:0]   w_cost_sat;
    logic                          w_ram_we;
    logic [rtue_pkg::COST_W-1:0]   w_ram_wdata;
    logic [rtue_pkg::ADDR_W-1:0]   w_waddr;
    logic [rtue_pkg::ADDR_W-1:0]   w_raddr;
    logic [rtue_pkg::COST_W-1:0]   w_rdata;
    logic [rtue_pkg::GATE_W-1:0]   w_cur_best;
    logic [rtue_pkg::COUNT_W-1:0]  w_count_next;
    logic                          w_sample;
    logic [rtue_pkg::GATE_W-1:0]   w_pick;
    logic                          w_best_moves;
    logic [NODES-1:0]              w_above;

    assign w_fits      = ({1'b0, i_item.node_id} < (rtue_pkg::NODE_W+1)'(NODES)) &&
                         ({1'b0, i_item.arrival_gate} < (rtue_pkg::GATE_W+1)'(GATES));
    assign w_new_node  = !r_known[i_item.node_id];
    assign w_disc      = i_acc && (i_item.command == rtue_pkg::CMD_DISCOVERY) &&
                         w_fits && w_new_node;
    assign w_adv_store = i_acc && (i_item.command == rtue_pkg::CMD_ADVERTISE) &&
                         w_fits && (i_item.node_id != r_own_node);

    assign w_cost_sum  = {1'b0, i_item.advertised_cost} + 1'b1;
    assign w_cost_sat  = w_cost_sum[rtue_pkg::COST_W] ? '1 : w_cost_sum[rtue_pkg::COST_W-1:0];

    assign w_ram_we    = w_disc || w_adv_store;
    assign w_ram_wdata = w_disc ? '0 : w_cost_sat;
    assign w_waddr     = {i_item.node_id, i_item.arrival_gate};
    assign w_cur_best  = r_best[i_cmd.node];
    assign w_raddr     = {i_cmd.node, i_cmd.sel_best ? w_cur_best : i_cmd.gate};

    rtue_ram #(
        .WIDTH (rtue_pkg::COST_W),
        .DEPTH (NODES * GATES)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_count_next = r_count + rtue_pkg::COUNT_W'(w_disc);

    // gate cost sample of the read issued in the previous cycle
    assign w_sample     = r_pend && r_mask[i_cmd.node][r_pend_gate];
    assign w_pick       = (r_best_cost == r_min) ? w_cur_best : r_arg;
    assign w_best_moves = i_cmd.scan_apply && (w_pick != w_cur_best);

    assign w_above      = (r_known >> i_cmd.node) >> 1;

    assign o_stat.disc_emit = (w_count_next == rtue_pkg::COUNT_W'(r_gate_count));
    assign o_stat.known     = r_known[i_cmd.node];
    assign o_stat.changed   = r_changed || w_best_moves;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_node   <= '0;
            r_gate_count <= rtue_pkg::GATE_COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rtue_pkg::REG_OWN_NODE:   r_own_node   <= i_cfg_data;
                rtue_pkg::REG_GATE_COUNT: r_gate_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known   <= '0;
            r_count   <= '0;
            r_changed <= 1'b0;
            for (int v = 0; v < NODES; v++) begin
                r_mask[v] <= '0;
                r_best[v] <= '0;
            end
        end else begin
            r_count <= w_count_next + rtue_pkg::COUNT_W'(w_adv_store && w_new_node);
            if (w_disc) begin
                r_known[i_item.node_id] <= 1'b1;
                r_mask[i_item.node_id]  <= GATES'(1) << i_item.arrival_gate;
                r_best[i_item.node_id]  <= i_item.arrival_gate;
            end
            if (w_adv_store) begin
                r_mask[i_item.node_id] <= r_mask[i_item.node_id] |
                                          (GATES'(1) << i_item.arrival_gate);
                if (w_new_node) begin
                    r_known[i_item.node_id] <= 1'b1;
                    r_best[i_item.node_id]  <= i_item.arrival_gate;
                end
            end
            if (w_best_moves) begin
                r_best[i_cmd.node] <= w_pick;
            end
            if (i_cmd.clr_changed) begin
                r_changed <= 1'b0;
            end else if (w_best_moves || (w_adv_store && w_new_node)) begin
                r_changed <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_min_vld <= 1'b0;
        end else begin
            r_pend <= i_cmd.scan_rd;
            if (i_cmd.scan_start) begin
                r_min_vld <= 1'b0;
            end else if (w_sample) begin
                r_min_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_gate <= i_cmd.gate;
        if (w_sample) begin
            if (!r_min_vld || (w_rdata < r_min)) begin
                r_min <= w_rdata;
                r_arg <= r_pend_gate;
            end
            if (r_pend_gate == w_cur_best) begin
                r_best_cost <= w_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out.dest_node   <= i_cmd.node;
            r_out.route_cost  <= w_rdata;
            r_out.final_entry <= ~|w_above;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
